// File: rtl/core/ellipsoid_surface_eval_assert.svh
// assertion macros used by the checker file
`ifndef ELLIPSOID_SURFACE_EVAL_ASSERT_SVH
`define ELLIPSOID_SURFACE_EVAL_ASSERT_SVH

// clocked property with reset gating
`define ESE_CLK_PROP(p) @(posedge clk) disable iff (!rst_n) (p)

// named concurrent assertion
`define ESE_ASSERT(label, p) \
    label: assert property (`ESE_CLK_PROP(p)) else $error("ese check failed");

`endif

// File: rtl/core/ese_pkg.sv
package ese_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int AXIS_W         = 16;
    localparam int VEC_W          = 48;
    localparam int KIND_W         = 3;
    localparam int CORDIC_STEPS   = 28;
    localparam int POST_STAGES    = 4;
    localparam int LANE_W         = 34;

    localparam logic [1:0] REG_AXIS_A = 2'd0;
    localparam logic [1:0] REG_AXIS_B = 2'd1;
    localparam logic [1:0] REG_AXIS_C = 2'd2;

    localparam logic [KIND_W-1:0] KIND_POS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DU  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DV  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NRM = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUU = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUV = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DVV = 3'd6;

    localparam logic signed [LANE_W-1:0] CORDIC_ONE = 34'sd652032874;
    localparam logic signed [LANE_W-1:0] Q30_ONE    = 34'sd1073741824;

    typedef struct packed {
        logic signed [LANE_W-1:0] x;
        logic signed [LANE_W-1:0] y;
        logic signed [LANE_W-1:0] z;
        logic                     neg;
    } lane_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] px;
        logic signed [VEC_W-1:0] py;
        logic signed [VEC_W-1:0] pz;
        logic signed [VEC_W-1:0] du_x;
        logic signed [VEC_W-1:0] du_y;
        logic signed [VEC_W-1:0] dv_x;
        logic signed [VEC_W-1:0] dv_y;
        logic signed [VEC_W-1:0] dv_z;
        logic signed [VEC_W-1:0] nrm_x;
        logic signed [VEC_W-1:0] nrm_y;
        logic signed [VEC_W-1:0] nrm_z;
        logic signed [VEC_W-1:0] duv_x;
        logic signed [VEC_W-1:0] duv_y;
    } term_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [LANE_W-1:0] atan_step(int step);
        logic signed [LANE_W-1:0] r;
        case (step)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004757;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            default: r = '0;
        endcase
        return r;
    endfunction

    // fold a 32-bit turn angle into [-1/4, 1/4) turn
    function automatic lane_t fold_angle(logic [31:0] t);
        lane_t l;
        logic [31:0] tf;
        l.neg = t[31] ^ t[30];
        tf = t;
        if (l.neg)
        begin
            tf[31] = ~t[31];
        end
        l.x = CORDIC_ONE;
        l.y = '0;
        l.z = {{(LANE_W-32){tf[31]}}, tf};
        return l;
    endfunction

    // clamp to [-1, 1] in Q30, then undo the fold
    function automatic logic signed [31:0] clamp_unit(logic signed [LANE_W-1:0] v, logic neg);
        logic signed [LANE_W-1:0] c;
        if (v > Q30_ONE)
        begin
            c = Q30_ONE;
        end
        else if (v < -Q30_ONE)
        begin
            c = -Q30_ONE;
        end
        else
        begin
            c = v;
        end
        if (neg)
        begin
            c = -c;
        end
        return c[31:0];
    endfunction

    // Q30 by Q30, rounded half up to Q30
    function automatic logic signed [31:0] mul30(logic signed [31:0] p, logic signed [31:0] q);
        logic signed [63:0] pr;
        logic signed [63:0] sh;
        pr = 64'(p) * 64'(q);
        pr = pr + 64'sd536870912;
        sh = pr >>> 30;
        return sh[31:0];
    endfunction

    // unsigned coefficient by Q30 term, rounded half up by sh bits
    function automatic logic signed [VEC_W-1:0] scale_term(logic [32:0] coef,
                                                           logic signed [31:0] t,
                                                           int unsigned sh);
        logic signed [65:0] prod;
        logic signed [65:0] r;
        prod = 66'($signed({1'b0, coef})) * 66'(t);
        prod = prod + (66'sd1 <<< (sh - 1));
        r = prod >>> sh;
        return r[VEC_W-1:0];
    endfunction

endpackage

// File: rtl/core/ese_cordic_cell.sv
module ese_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           en,
    input  ese_pkg::lane_t lane_in,
    output ese_pkg::lane_t lane_out
);
    import ese_pkg::*;

    lane_t lane_reg;
    lane_t lane_next;
    logic signed [LANE_W-1:0] dx;
    logic signed [LANE_W-1:0] dy;

    always_comb
    begin
        dx = lane_in.y >>> STEP;
        dy = lane_in.x >>> STEP;
        lane_next = lane_in;
        if (!lane_in.z[LANE_W-1])
        begin
            lane_next.x = lane_in.x - dx;
            lane_next.y = lane_in.y + dy;
            lane_next.z = lane_in.z - atan_step(STEP);
        end
        else
        begin
            lane_next.x = lane_in.x + dx;
            lane_next.y = lane_in.y - dy;
            lane_next.z = lane_in.z + atan_step(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// File: rtl/core/ese_product.sv
module ese_product #(
    parameter int FRAC_BITS = ese_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  ese_pkg::lane_t                lane_u,
    input  ese_pkg::lane_t                lane_v,
    input  logic [ese_pkg::AXIS_W-1:0]    axis_a,
    input  logic [ese_pkg::AXIS_W-1:0]    axis_b,
    input  logic [ese_pkg::AXIS_W-1:0]    axis_c,
    output ese_pkg::term_t                terms
);
    import ese_pkg::*;

    localparam int unsigned SH1 = 38 - FRAC_BITS;
    localparam int unsigned SH2 = 46 - FRAC_BITS;

    // stage 1: clamp and unfold, axis products
    logic signed [31:0] cu_reg, su_reg, cv_reg, sv_reg;
    logic [31:0] ab_reg, ac_reg, bc_reg;
    // stage 2: trig products
    logic signed [31:0] cusv_reg, susv_reg, cucv_reg, sucv_reg, svsv_reg, svcv_reg;
    logic signed [31:0] cu2_reg, su2_reg, cv2_reg, sv2_reg;
    // stage 3: axis scaling
    term_t t3_reg;
    logic signed [31:0] n1_reg, n2_reg;
    // stage 4: normal x and y
    term_t t4_reg;
    term_t t4_next;

    always_comb
    begin
        t4_next = t3_reg;
        t4_next.nrm_x = -scale_term({1'b0, bc_reg}, n1_reg, SH2);
        t4_next.nrm_y = -scale_term({1'b0, ac_reg}, n2_reg, SH2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cu_reg <= clamp_unit(lane_u.x, lane_u.neg);
            su_reg <= clamp_unit(lane_u.y, lane_u.neg);
            cv_reg <= clamp_unit(lane_v.x, lane_v.neg);
            sv_reg <= clamp_unit(lane_v.y, lane_v.neg);
            ab_reg <= 32'(axis_a) * 32'(axis_b);
            ac_reg <= 32'(axis_a) * 32'(axis_c);
            bc_reg <= 32'(axis_b) * 32'(axis_c);

            cusv_reg <= mul30(cu_reg, sv_reg);
            susv_reg <= mul30(su_reg, sv_reg);
            cucv_reg <= mul30(cu_reg, cv_reg);
            sucv_reg <= mul30(su_reg, cv_reg);
            svsv_reg <= mul30(sv_reg, sv_reg);
            svcv_reg <= mul30(sv_reg, cv_reg);
            cu2_reg  <= cu_reg;
            su2_reg  <= su_reg;
            cv2_reg  <= cv_reg;
            sv2_reg  <= sv_reg;

            n1_reg       <= mul30(svsv_reg, cu2_reg);
            n2_reg       <= mul30(svsv_reg, su2_reg);
            t3_reg.px    <= scale_term({17'd0, axis_a}, cusv_reg, SH1);
            t3_reg.py    <= scale_term({17'd0, axis_b}, susv_reg, SH1);
            t3_reg.pz    <= scale_term({17'd0, axis_c}, cv2_reg, SH1);
            t3_reg.du_x  <= -scale_term({17'd0, axis_a}, susv_reg, SH1);
            t3_reg.du_y  <= scale_term({17'd0, axis_b}, cusv_reg, SH1);
            t3_reg.dv_x  <= scale_term({17'd0, axis_a}, cucv_reg, SH1);
            t3_reg.dv_y  <= scale_term({17'd0, axis_b}, sucv_reg, SH1);
            t3_reg.dv_z  <= -scale_term({17'd0, axis_c}, sv2_reg, SH1);
            t3_reg.nrm_x <= '0;
            t3_reg.nrm_y <= '0;
            t3_reg.nrm_z <= -scale_term({1'b0, ab_reg}, svcv_reg, SH2);
            t3_reg.duv_x <= -scale_term({17'd0, axis_a}, sucv_reg, SH1);
            t3_reg.duv_y <= scale_term({17'd0, axis_b}, cucv_reg, SH1);

            t4_reg <= t4_next;
        end
    end

    assign terms = t4_reg;

endmodule

// File: rtl/core/ese_out.sv
module ese_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  ese_pkg::term_t                terms,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ese_pkg::KIND_W-1:0]    vector_kind,
    output logic signed [ese_pkg::VEC_W-1:0] vector_x,
    output logic signed [ese_pkg::VEC_W-1:0] vector_y,
    output logic signed [ese_pkg::VEC_W-1:0] vector_z,
    output logic                          last_vector
);
    import ese_pkg::*;

    term_t term_reg;
    logic hold_valid_reg;
    logic hold_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_next;
    logic take;

    assign take = hold_valid_reg && !out_stall;
    assign room = !hold_valid_reg || (take && kind_reg == KIND_DVV);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        kind_next = kind_reg;
        if (load)
        begin
            hold_valid_next = 1'b1;
            kind_next = KIND_POS;
        end
        else if (take)
        begin
            if (kind_reg == KIND_DVV)
            begin
                hold_valid_next = 1'b0;
            end
            else
            begin
                kind_next = kind_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            kind_reg <= KIND_POS;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_reg <= terms;
        end
    end

    always_comb
    begin
        case (kind_reg)
            KIND_POS:
            begin
                vector_x = term_reg.px;
                vector_y = term_reg.py;
                vector_z = term_reg.pz;
            end
            KIND_DU:
            begin
                vector_x = term_reg.du_x;
                vector_y = term_reg.du_y;
                vector_z = '0;
            end
            KIND_DV:
            begin
                vector_x = term_reg.dv_x;
                vector_y = term_reg.dv_y;
                vector_z = term_reg.dv_z;
            end
            KIND_NRM:
            begin
                vector_x = term_reg.nrm_x;
                vector_y = term_reg.nrm_y;
                vector_z = term_reg.nrm_z;
            end
            KIND_DUU:
            begin
                vector_x = -term_reg.px;
                vector_y = -term_reg.py;
                vector_z = '0;
            end
            KIND_DUV:
            begin
                vector_x = term_reg.duv_x;
                vector_y = term_reg.duv_y;
                vector_z = '0;
            end
            default:
            begin
                vector_x = -term_reg.px;
                vector_y = -term_reg.py;
                vector_z = -term_reg.pz;
            end
        endcase
    end

    assign out_valid = hold_valid_reg;
    assign vector_kind = kind_reg;
    assign last_vector = (kind_reg == KIND_DVV);

endmodule

// File: rtl/core/ellipsoid_surface_eval.sv
// an accepted input pair passes the cordic cells, the product stages and the hold register to its first result vector
// throughput: one result vector per cycle while out_stall is low, set by the single result channel draining
// the seven-vector hold register; input and chain stall until its last vector is taken
// reset: semi-axes return to 1.0 (256), all pipeline valid bits and the hold clear
module ellipsoid_surface_eval #(
    parameter int ANGLE_BITS = ese_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ese_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_write_en,
    input  logic [1:0]                       cfg_index,
    input  logic [ese_pkg::AXIS_W-1:0]       cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ANGLE_BITS-1:0]            angle_u,
    input  logic [ANGLE_BITS-1:0]            angle_v,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ese_pkg::KIND_W-1:0]       vector_kind,
    output logic signed [ese_pkg::VEC_W-1:0] vector_x,
    output logic signed [ese_pkg::VEC_W-1:0] vector_y,
    output logic signed [ese_pkg::VEC_W-1:0] vector_z,
    output logic                             last_vector
);
    import ese_pkg::*;

    localparam int PIPE_DEPTH = CORDIC_STEPS + POST_STAGES;

    // semi-axis registers, unsigned q8.8
    logic [AXIS_W-1:0] axis_a_reg;
    logic [AXIS_W-1:0] axis_b_reg;
    logic [AXIS_W-1:0] axis_c_reg;

    // one valid bit per pipeline stage; the whole chain moves together
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic advance;
    logic room;

    // cordic chain, one lane for each angle
    lane_t chain_u [CORDIC_STEPS+1];
    lane_t chain_v [CORDIC_STEPS+1];
    term_t terms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_a_reg <= 16'd256;
            axis_b_reg <= 16'd256;
            axis_c_reg <= 16'd256;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_AXIS_A: axis_a_reg <= cfg_data;
                REG_AXIS_B: axis_b_reg <= cfg_data;
                REG_AXIS_C: axis_c_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // the chain advances whenever the hold register can take the tail
    assign advance = room;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // angles scaled up to a 32-bit turn and folded to the right half plane
    assign chain_u[0] = fold_angle({angle_u, {(32-ANGLE_BITS){1'b0}}});
    assign chain_v[0] = fold_angle({angle_v, {(32-ANGLE_BITS){1'b0}}});

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        ese_cordic_cell #(.STEP(i)) u_cell_u (
            .clk      (clk),
            .en       (advance),
            .lane_in  (chain_u[i]),
            .lane_out (chain_u[i+1])
        );
        ese_cordic_cell #(.STEP(i)) u_cell_v (
            .clk      (clk),
            .en       (advance),
            .lane_in  (chain_v[i]),
            .lane_out (chain_v[i+1])
        );
    end

    // products and axis scaling, four stages
    ese_product #(.FRAC_BITS(FRAC_BITS)) u_product (
        .clk    (clk),
        .en     (advance),
        .lane_u (chain_u[CORDIC_STEPS]),
        .lane_v (chain_v[CORDIC_STEPS]),
        .axis_a (axis_a_reg),
        .axis_b (axis_b_reg),
        .axis_c (axis_c_reg),
        .terms  (terms)
    );

    // hold register, emits the seven vectors of one transaction in order
    ese_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && valid_reg[PIPE_DEPTH-1]),
        .terms       (terms),
        .room        (room),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .vector_kind (vector_kind),
        .vector_x    (vector_x),
        .vector_y    (vector_y),
        .vector_z    (vector_z),
        .last_vector (last_vector)
    );

endmodule

// File: rtl/core/ese_checker.sv
`include "ellipsoid_surface_eval_assert.svh"

module ese_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [ese_pkg::KIND_W-1:0]       vector_kind,
    input logic signed [ese_pkg::VEC_W-1:0] vector_z,
    input logic                             last_vector
);
    import ese_pkg::*;

    `ESE_ASSERT(a_last_on_dvv, out_valid |-> (last_vector == (vector_kind == KIND_DVV)))
    `ESE_ASSERT(a_burst_stays, (out_valid && !out_stall && !last_vector) |=> out_valid)
    `ESE_ASSERT(a_kind_steps, (out_valid && !out_stall && !last_vector) |=> (vector_kind == $past(vector_kind) + 3'd1))
    `ESE_ASSERT(a_du_z_zero, (out_valid && vector_kind == KIND_DU) |-> (vector_z == '0))

endmodule

bind ellipsoid_surface_eval ese_checker u_ese_checker (.*);
